// ----- hw/rtl/vcrp_pkg.sv -----
// Shared types, constants and helpers for the vicinity card response parser.
package vcrp_pkg;

   localparam int UID_BYTES     = 8;
   localparam int UID_W         = 8 * UID_BYTES;
   localparam int EXTRA_BYTES   = 5;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 9;

   localparam logic [9:0] COUNTER_MAX     = 10'd1023;
   localparam logic [9:0] UID_END_POS     = 10'(1 + UID_BYTES);
   localparam logic [9:0] MIN_INFO_LEN    = 10'(2 + UID_BYTES);
   localparam logic [2:0] EXTRA_POS_MAX   = 3'd7;
   localparam int         FLAG_ERROR_BIT  = 0;
   localparam int         SI_DSFID_BIT    = 0;
   localparam int         SI_AFI_BIT      = 1;
   localparam int         SI_MEMORY_BIT   = 2;
   localparam int         SI_ICREF_BIT    = 3;
   localparam logic [7:0] ERR_CUSTOM_LO   = 8'hA0;
   localparam logic [7:0] ERR_CUSTOM_HI   = 8'hDF;
   localparam logic [7:0] ERR_NOT_SUPP_A  = 8'h01;
   localparam logic [7:0] ERR_NOT_SUPP_B  = 8'h03;
   localparam logic [7:0] ERR_FORMAT      = 8'h02;
   localparam logic [7:0] ERR_INTERNAL_LO = 8'h10;
   localparam logic [7:0] ERR_INTERNAL_HI = 8'h14;
   localparam logic [4:0] BLOCK_SIZE_MASK = 5'h1F;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_LAST  = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RESP_INVENTORY      = 2'd0,
      RESP_SYSINFO        = 2'd1,
      RESP_READ_BLOCK     = 2'd2,
      RESP_BLOCK_SECURITY = 2'd3
   } response_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RESPONSE    = 2'd0,
      CSR_BLOCK_SIZE  = 2'd1,
      CSR_BLOCK_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_EMPTY         = 3'd1,
      ST_UNEXPECTED    = 3'd2,
      ST_CUSTOM        = 3'd3,
      ST_NOT_SUPPORTED = 3'd4,
      ST_FORMAT        = 3'd5,
      ST_INTERNAL      = 3'd6,
      ST_UNKNOWN       = 3'd7
   } status_type;

   typedef struct packed {
      logic             is_status;
      logic [7:0]       payload_byte;
      logic [7:0]       payload_index;
      status_type       status;
      logic [UID_W-1:0] tag_uid;
      logic [7:0]       info_flags;
      logic [7:0]       dsfid_value;
      logic [7:0]       afi_value;
      logic [8:0]       block_total;
      logic [5:0]       block_bytes;
      logic [7:0]       ic_reference;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic status_type classify_error(input logic [7:0] code);
      status_type st;
      if (code >= ERR_CUSTOM_LO && code <= ERR_CUSTOM_HI) begin
         st = ST_CUSTOM;
      end else if (code == ERR_NOT_SUPP_A || code == ERR_NOT_SUPP_B) begin
         st = ST_NOT_SUPPORTED;
      end else if (code == ERR_FORMAT) begin
         st = ST_FORMAT;
      end else if (code >= ERR_INTERNAL_LO && code <= ERR_INTERNAL_HI) begin
         st = ST_INTERNAL;
      end else begin
         st = ST_UNKNOWN;
      end
      return st;
   endfunction

endpackage

// ----- hw/rtl/vcrp_if.sv -----
// Valid/ready channel interfaces for frame bytes and parser results.
interface vcrp_req_if;
   import vcrp_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] frame_byte;

   modport source (output valid, output kind, output frame_byte, input ready);
   modport sink (input valid, input kind, input frame_byte, output ready);
endinterface

interface vcrp_rsp_if;
   import vcrp_pkg::*;
   logic             valid;
   logic             ready;
   logic             is_status;
   logic [7:0]       payload_byte;
   logic [7:0]       payload_index;
   logic [2:0]       status;
   logic [UID_W-1:0] tag_uid;
   logic [7:0]       info_flags;
   logic [7:0]       dsfid_value;
   logic [7:0]       afi_value;
   logic [8:0]       block_total;
   logic [5:0]       block_bytes;
   logic [7:0]       ic_reference;

   modport source (output valid, output is_status, output payload_byte,
                   output payload_index, output status, output tag_uid,
                   output info_flags, output dsfid_value, output afi_value,
                   output block_total, output block_bytes, output ic_reference,
                   input ready);
   modport sink (input valid, input is_status, input payload_byte,
                 input payload_index, input status, input tag_uid,
                 input info_flags, input dsfid_value, input afi_value,
                 input block_total, input block_bytes, input ic_reference,
                 output ready);
endinterface

// ----- hw/rtl/vcrp_parse.sv -----
// Frame state, configuration registers and per-byte result generation.
module vcrp_parse (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [vcrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vcrp_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             in_fire,
   input  logic [1:0]                       kind,
   input  logic [7:0]                       frame_byte,
   output vcrp_pkg::push_type               push
);
   import vcrp_pkg::*;

   response_type     resp_ff;
   logic [5:0]       block_size_ff;
   logic [8:0]       block_count_ff;

   logic [9:0]       counter_ff, counter_in;
   logic             err_flag_ff, err_flag_in;
   logic [7:0]       code_ff, code_in;
   logic [UID_W-1:0] uid_ff, uid_in;
   logic [7:0]       extra_ff [EXTRA_BYTES];
   logic [7:0]       extra_in [EXTRA_BYTES];
   logic [2:0]       xpos_ff, xpos_in;

   logic [UID_W-1:0] held_uid_ff, held_uid_in;
   logic [7:0]       held_flags_ff, held_flags_in;
   logic [7:0]       held_dsfid_ff, held_dsfid_in;
   logic [7:0]       held_afi_ff, held_afi_in;
   logic [8:0]       held_total_ff, held_total_in;
   logic [5:0]       held_bytes_ff, held_bytes_in;
   logic [7:0]       held_ic_ff, held_ic_in;

   logic             is_byte, is_end, emit_payload, ok;
   logic [9:0]       pos;
   logic [2:0]       need, k_mem, k_ic;
   logic [7:0]       afi_sel, cnt_sel, size_sel, ic_sel;
   status_type       st;
   result_type       pay_res, st_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_ff        <= RESP_INVENTORY;
         block_size_ff  <= 6'd4;
         block_count_ff <= 9'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RESPONSE:    resp_ff        <= response_type'(csr_write_data[1:0]);
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_write_data[5:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      is_byte = in_fire && (kind == KIND_BYTE || kind == KIND_LAST);
      is_end  = in_fire && (kind == KIND_LAST || kind == KIND_EMPTY);
      pos     = counter_ff;

      counter_in  = counter_ff;
      err_flag_in = err_flag_ff;
      code_in     = code_ff;
      uid_in      = uid_ff;
      xpos_in     = xpos_ff;
      for (int i = 0; i < EXTRA_BYTES; i++) begin
         extra_in[i] = extra_ff[i];
      end
      emit_payload = 1'b0;

      if (is_byte) begin
         if (pos == 10'd0) begin
            err_flag_in = frame_byte[FLAG_ERROR_BIT];
         end else begin
            if (pos == 10'd1) begin
               code_in = frame_byte;
            end else if (pos <= UID_END_POS) begin
               uid_in = {uid_ff[UID_W-9:0], frame_byte};
            end else begin
               for (int i = 0; i < EXTRA_BYTES; i++) begin
                  if (pos == MIN_INFO_LEN + 10'(i)) extra_in[i] = frame_byte;
               end
               if (xpos_ff != EXTRA_POS_MAX) xpos_in = xpos_ff + 3'd1;
            end
            emit_payload = (resp_ff == RESP_READ_BLOCK || resp_ff == RESP_BLOCK_SECURITY)
                           && !err_flag_ff;
         end
         if (counter_ff != COUNTER_MAX) counter_in = counter_ff + 10'd1;
      end

      // System info field selection; each optional field shifts the later ones.
      need  = 3'(code_in[SI_DSFID_BIT]) + 3'(code_in[SI_AFI_BIT])
            + {1'b0, code_in[SI_MEMORY_BIT], 1'b0} + 3'(code_in[SI_ICREF_BIT]);
      afi_sel = code_in[SI_DSFID_BIT] ? extra_in[1] : extra_in[0];
      k_mem = 3'(code_in[SI_DSFID_BIT]) + 3'(code_in[SI_AFI_BIT]);
      k_ic  = k_mem + {1'b0, code_in[SI_MEMORY_BIT], 1'b0};
      case (k_mem)
         3'd0:    begin cnt_sel = extra_in[0]; size_sel = extra_in[1]; end
         3'd1:    begin cnt_sel = extra_in[1]; size_sel = extra_in[2]; end
         default: begin cnt_sel = extra_in[2]; size_sel = extra_in[3]; end
      endcase
      case (k_ic)
         3'd0:    ic_sel = extra_in[0];
         3'd1:    ic_sel = extra_in[1];
         3'd2:    ic_sel = extra_in[2];
         3'd3:    ic_sel = extra_in[3];
         default: ic_sel = extra_in[4];
      endcase

      held_uid_in   = held_uid_ff;
      held_flags_in = held_flags_ff;
      held_dsfid_in = held_dsfid_ff;
      held_afi_in   = held_afi_ff;
      held_total_in = held_total_ff;
      held_bytes_in = held_bytes_ff;
      held_ic_in    = held_ic_ff;

      ok = 1'b0;
      st = ST_UNEXPECTED;
      if (counter_in == 10'd0) begin
         st = ST_EMPTY;
      end else if (err_flag_in) begin
         st = (counter_in < 10'd2) ? ST_UNEXPECTED : classify_error(code_in);
      end else begin
         case (resp_ff)
            RESP_INVENTORY:  ok = (counter_in == MIN_INFO_LEN);
            RESP_SYSINFO:    ok = (counter_in >= MIN_INFO_LEN) && (xpos_in == need);
            RESP_READ_BLOCK: ok = (counter_in > 10'd1)
                                  && ((counter_in - 10'd1) == {4'd0, block_size_ff});
            default:         ok = (counter_in > 10'd1)
                                  && ((counter_in - 10'd1) == {1'b0, block_count_ff});
         endcase
         if (ok) st = ST_OK;
      end

      if (is_end && ok) begin
         if (resp_ff == RESP_INVENTORY) begin
            held_uid_in = uid_in;
         end else if (resp_ff == RESP_SYSINFO) begin
            held_flags_in = code_in;
            if (code_in[SI_DSFID_BIT]) held_dsfid_in = extra_in[0];
            if (code_in[SI_AFI_BIT])   held_afi_in   = afi_sel;
            if (code_in[SI_MEMORY_BIT]) begin
               held_total_in = {1'b0, cnt_sel} + 9'd1;
               held_bytes_in = {1'b0, size_sel[4:0] & BLOCK_SIZE_MASK} + 6'd1;
            end
            if (code_in[SI_ICREF_BIT]) held_ic_in = ic_sel;
         end
      end

      st_res.is_status     = 1'b1;
      st_res.payload_byte  = 8'd0;
      st_res.payload_index = 8'd0;
      st_res.status        = st;
      st_res.tag_uid       = held_uid_in;
      st_res.info_flags    = held_flags_in;
      st_res.dsfid_value   = held_dsfid_in;
      st_res.afi_value     = held_afi_in;
      st_res.block_total   = held_total_in;
      st_res.block_bytes   = held_bytes_in;
      st_res.ic_reference  = held_ic_in;

      // Held fields never change on a step that streams payload.
      pay_res               = st_res;
      pay_res.is_status     = 1'b0;
      pay_res.payload_byte  = frame_byte;
      pay_res.payload_index = 8'(pos - 10'd1);
      pay_res.status        = ST_OK;

      push.count  = 2'(emit_payload) + 2'(is_end);
      push.first  = emit_payload ? pay_res : st_res;
      push.second = st_res;

      if (is_end) begin
         counter_in  = 10'd0;
         err_flag_in = 1'b0;
         xpos_in     = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff    <= 10'd0;
         err_flag_ff   <= 1'b0;
         xpos_ff       <= 3'd0;
         held_uid_ff   <= '0;
         held_flags_ff <= 8'd0;
         held_dsfid_ff <= 8'd0;
         held_afi_ff   <= 8'd0;
         held_total_ff <= 9'd0;
         held_bytes_ff <= 6'd0;
         held_ic_ff    <= 8'd0;
      end else begin
         counter_ff    <= counter_in;
         err_flag_ff   <= err_flag_in;
         xpos_ff       <= xpos_in;
         held_uid_ff   <= held_uid_in;
         held_flags_ff <= held_flags_in;
         held_dsfid_ff <= held_dsfid_in;
         held_afi_ff   <= held_afi_in;
         held_total_ff <= held_total_in;
         held_bytes_ff <= held_bytes_in;
         held_ic_ff    <= held_ic_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      uid_ff  <= uid_in;
      for (int i = 0; i < EXTRA_BYTES; i++) begin
         extra_ff[i] <= extra_in[i];
      end
   end

endmodule

// ----- hw/rtl/vcrp_queue.sv -----
// Result queue taking up to two results per cycle and giving one per cycle while out_ready is high.
module vcrp_queue #(
   parameter int DEPTH = vcrp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vcrp_pkg::push_type   push,
   input  logic                 out_ready,
   output logic                 out_valid,
   output vcrp_pkg::result_type out_data,
   output logic                 space_ok
);
   import vcrp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   result_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      out_valid = (count_ff != '0);
      out_data  = entry_ff[rd_ptr_ff];
      space_ok  = (count_ff <= CNT_W'(DEPTH - 2));
      pop       = out_valid && out_ready;
      wr_next   = step_ptr(wr_ptr_ff);
      rd_ptr_in = pop ? step_ptr(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_next;
         default: wr_ptr_in = step_ptr(wr_next);
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next]   <= push.second;
   end

endmodule

// ----- hw/rtl/vicinity_card_response_parser_top.sv -----
// Vicinity card response parser: top level.
//
// req_bus carries one transaction per received byte: kind says whether the
// byte is inside the frame, the last of it, or whether the frame ended with
// no byte (kind 3 is dropped). rsp_bus gives read block and block security
// payload bytes as they arrive, then one status transaction per frame with
// the held UID and system information fields.
// The csr_ port writes expected response type, block size and block count;
// write only while no frame is in progress and rsp_bus has drained.
// Each byte is parsed in the cycle it is accepted and its one or two results
// land in a four-entry queue; the first result is registered there and
// reaches rsp_bus once older entries are taken. One byte is accepted per
// cycle while the queue holds two entries or fewer, so a byte that yields
// two results leaves room for the following one only if no older entry stays.
// When the receiver stalls the queue fills and req_bus.ready drops.
// Synchronous reset clears the frame state, held fields and queue, and
// loads the register defaults (inventory, block size 4, block count 1).
module vicinity_card_response_parser_top #(
   parameter int QUEUE_DEPTH = vcrp_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [vcrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vcrp_pkg::CSR_DATA_W-1:0]  csr_write_data,
   vcrp_req_if.sink                         req_bus,
   vcrp_rsp_if.source                       rsp_bus
);
   import vcrp_pkg::*;

   push_type   push;
   result_type head;
   logic       space_ok;
   logic       in_fire;

   assign in_fire       = req_bus.valid && space_ok;
   assign req_bus.ready = space_ok;

   vcrp_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_fire          (in_fire),
      .kind             (req_bus.kind),
      .frame_byte       (req_bus.frame_byte),
      .push             (push)
   );

   vcrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_data  (head),
      .space_ok  (space_ok)
   );

   assign rsp_bus.is_status     = head.is_status;
   assign rsp_bus.payload_byte  = head.payload_byte;
   assign rsp_bus.payload_index = head.payload_index;
   assign rsp_bus.status        = head.status;
   assign rsp_bus.tag_uid       = head.tag_uid;
   assign rsp_bus.info_flags    = head.info_flags;
   assign rsp_bus.dsfid_value   = head.dsfid_value;
   assign rsp_bus.afi_value     = head.afi_value;
   assign rsp_bus.block_total   = head.block_total;
   assign rsp_bus.block_bytes   = head.block_bytes;
   assign rsp_bus.ic_reference  = head.ic_reference;

endmodule
